FILE: rtl/wcrc_pkg.sv
// wcrc_pkg: item types, status codes, register indexes and reset values
// for the wheel and crank rate calculator; no dependencies
package wcrc_pkg;

  typedef struct packed {
    logic        func;
    logic [31:0] rev_count;
    logic [15:0] event_time;
  } in_item_t;

  typedef struct packed {
    logic [15:0] rate_value;
    logic [1:0]  status;
  } out_item_t;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FIRST = 2'd1;
  localparam logic [1:0] STATUS_STILL = 2'd2;
  localparam logic [1:0] STATUS_LIMIT = 2'd3;

  localparam logic [1:0] REG_CIRCUMFERENCE = 2'd0;
  localparam logic [1:0] REG_SPEED_LIMIT   = 2'd1;
  localparam logic [1:0] REG_CADENCE_LIMIT = 2'd2;

  localparam logic        FUNC_WHEEL = 1'b0;
  localparam logic        FUNC_CRANK = 1'b1;

  localparam logic [15:0] CIRCUMFERENCE_RESET = 16'd2096;
  localparam logic [15:0] SPEED_LIMIT_RESET   = 16'd10000;
  localparam logic [7:0]  CADENCE_LIMIT_RESET = 8'd250;

  // crank factor 60 * 1024
  localparam logic [31:0] CRANK_FACTOR = 32'd61440;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

endpackage

FILE: rtl/wheel_crank_rate_calculator_unit.sv
// wheel_crank_rate_calculator_unit: speed and cadence from sensor reports,
// bit-serial shift-add multiply then radix-2 restoring divide
// depends on wcrc_pkg
//
// channel   ports                               direction
// in        in_valid, in_ready, in_data         report items in
// out       out_valid, out_ready, out_data      result items out
// cfg       cfg_valid, cfg_ready, cfg_index,    register writes in
//           cfg_data
//
// first report and no-motion items go from ST_IDLE straight to ST_FIN
// rate items pass ST_MUL and ST_DIV before ST_FIN: 32 multiply
// steps and 64 divide steps through one 64-bit shift register, one bit per cycle
// one item in work at a time; result register lets a new item in while
// the last result waits, a second finished result holds the input off until
// the first is taken; sync active-low reset clears control, config and history
module wheel_crank_rate_calculator_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  wcrc_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output wcrc_pkg::out_item_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [15:0]          cfg_data
);
  import wcrc_pkg::*;

  state_t      state_r, state_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [63:0] prod_r, prod_nxt;
  logic [31:0] mcand_r, mcand_nxt;
  logic [22:0] divisor_r, divisor_nxt;
  logic [22:0] rem_r, rem_nxt;
  logic        kind_r, kind_nxt;
  out_item_t   res_r, res_nxt;
  out_item_t   out_data_r, out_data_nxt;
  logic        out_valid_r, out_valid_nxt;

  logic [15:0] circ_r, circ_nxt;
  logic [15:0] speed_lim_r, speed_lim_nxt;
  logic [7:0]  cad_lim_r, cad_lim_nxt;

  logic        wheel_seen_r, wheel_seen_nxt;
  logic [31:0] wheel_revs_r, wheel_revs_nxt;
  logic [15:0] wheel_time_r, wheel_time_nxt;
  logic        crank_seen_r, crank_seen_nxt;
  logic [15:0] crank_revs_r, crank_revs_nxt;
  logic [15:0] crank_time_r, crank_time_nxt;

  logic        in_acc;
  logic [31:0] w_drev;
  logic [15:0] w_dt;
  logic [15:0] c_drev;
  logic [15:0] c_dt;
  logic [32:0] mul_sum;
  logic [23:0] div_try;
  logic        div_ge;
  logic [23:0] div_diff;
  logic [15:0] lim;
  logic        out_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || out_ready;

  assign w_drev = in_data.rev_count - wheel_revs_r;
  assign w_dt   = in_data.event_time - wheel_time_r;
  assign c_drev = in_data.rev_count[15:0] - crank_revs_r;
  assign c_dt   = in_data.event_time - crank_time_r;

  assign mul_sum  = {1'b0, prod_r[63:32]} + (prod_r[0] ? {1'b0, mcand_r} : 33'd0);
  assign div_try  = {rem_r, prod_r[63]};
  assign div_ge   = div_try >= {1'b0, divisor_r};
  assign div_diff = div_try - {1'b0, divisor_r};
  assign lim      = (kind_r == FUNC_WHEEL) ? speed_lim_r : {8'd0, cad_lim_r};

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    prod_nxt       = prod_r;
    mcand_nxt      = mcand_r;
    divisor_nxt    = divisor_r;
    rem_nxt        = rem_r;
    kind_nxt       = kind_r;
    res_nxt        = res_r;
    out_data_nxt   = out_data_r;
    out_valid_nxt  = out_valid_r;
    circ_nxt       = circ_r;
    speed_lim_nxt  = speed_lim_r;
    cad_lim_nxt    = cad_lim_r;
    wheel_seen_nxt = wheel_seen_r;
    wheel_revs_nxt = wheel_revs_r;
    wheel_time_nxt = wheel_time_r;
    crank_seen_nxt = crank_seen_r;
    crank_revs_nxt = crank_revs_r;
    crank_time_nxt = crank_time_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_valid) begin
      unique case (cfg_index)
        REG_CIRCUMFERENCE: begin
          if (cfg_data != 16'd0) begin
            circ_nxt = cfg_data;
          end
        end
        REG_SPEED_LIMIT:   speed_lim_nxt = cfg_data;
        REG_CADENCE_LIMIT: cad_lim_nxt = cfg_data[7:0];
        default: ;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          kind_nxt = in_data.func;
          res_nxt  = '{rate_value: 16'd0, status: STATUS_STILL};
          cnt_nxt  = 6'd0;
          rem_nxt  = 23'd0;
          state_nxt = ST_FIN;
          if (in_data.func == FUNC_WHEEL) begin
            wheel_seen_nxt = 1'b1;
            wheel_revs_nxt = in_data.rev_count;
            wheel_time_nxt = in_data.event_time;
            // circumference * 1024 * 36
            mcand_nxt   = {1'b0, circ_r, 15'd0} + {4'd0, circ_r, 12'd0};
            // dt * 100
            divisor_nxt = {1'b0, w_dt, 6'd0} + {2'd0, w_dt, 5'd0}
                        + {5'd0, w_dt, 2'd0};
            prod_nxt    = {32'd0, w_drev};
            if (!wheel_seen_r) begin
              res_nxt.status = STATUS_FIRST;
            end else if (w_drev != 32'd0 && w_dt != 16'd0) begin
              state_nxt = ST_MUL;
            end
          end else begin
            crank_seen_nxt = 1'b1;
            crank_revs_nxt = in_data.rev_count[15:0];
            crank_time_nxt = in_data.event_time;
            mcand_nxt   = CRANK_FACTOR;
            divisor_nxt = {7'd0, c_dt};
            prod_nxt    = {48'd0, c_drev};
            if (!crank_seen_r) begin
              res_nxt.status = STATUS_FIRST;
            end else if (c_drev != 16'd0 && c_dt != 16'd0) begin
              state_nxt = ST_MUL;
            end
          end
        end
      end
      ST_MUL: begin
        prod_nxt = {mul_sum, prod_r[31:1]};
        cnt_nxt  = cnt_r + 6'd1;
        if (cnt_r == 6'd31) begin
          cnt_nxt   = 6'd0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_nxt  = div_ge ? div_diff[22:0] : div_try[22:0];
        prod_nxt = {prod_r[62:0], div_ge};
        cnt_nxt  = cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          state_nxt = ST_FIN;
          if ((|prod_nxt[63:16]) || (prod_nxt[15:0] > lim)) begin
            res_nxt = '{rate_value: 16'd0, status: STATUS_LIMIT};
          end else begin
            res_nxt = '{rate_value: prod_nxt[15:0], status: STATUS_OK};
          end
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_data_nxt  = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= 6'd0;
      out_valid_r  <= 1'b0;
      circ_r       <= CIRCUMFERENCE_RESET;
      speed_lim_r  <= SPEED_LIMIT_RESET;
      cad_lim_r    <= CADENCE_LIMIT_RESET;
      wheel_seen_r <= 1'b0;
      wheel_revs_r <= 32'd0;
      wheel_time_r <= 16'd0;
      crank_seen_r <= 1'b0;
      crank_revs_r <= 16'd0;
      crank_time_r <= 16'd0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      out_valid_r  <= out_valid_nxt;
      circ_r       <= circ_nxt;
      speed_lim_r  <= speed_lim_nxt;
      cad_lim_r    <= cad_lim_nxt;
      wheel_seen_r <= wheel_seen_nxt;
      wheel_revs_r <= wheel_revs_nxt;
      wheel_time_r <= wheel_time_nxt;
      crank_seen_r <= crank_seen_nxt;
      crank_revs_r <= crank_revs_nxt;
      crank_time_r <= crank_time_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r     <= prod_nxt;
    mcand_r    <= mcand_nxt;
    divisor_r  <= divisor_nxt;
    rem_r      <= rem_nxt;
    kind_r     <= kind_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

FILE: verif/tb_wheel_crank_rate_calculator_unit.sv
// tb_wheel_crank_rate_calculator_unit: self-checking bench for the wheel and crank rate unit,
// directed reports, register extremes and random sensor streams under varied idling
// depends on wcrc_pkg and wheel_crank_rate_calculator_unit
`timescale 1ns / 100ps

module tb_wheel_crank_rate_calculator_unit;
  import wcrc_pkg::*;

  localparam int CLK_HALF       = 2;
  localparam int RESET_CYCLES   = 7;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_LIMIT    = 20000;
  localparam int SETTLE_CYCLES  = 110;
  localparam int HOLD_LEN       = 400;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  in_item_t    in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data  = '0;

  // predictor copy of registers and sensor history
  logic [15:0] cur_circumference;
  logic [15:0] cur_speed_limit;
  logic [7:0]  cur_cadence_limit;
  logic        wheel_armed;
  logic [31:0] wheel_revs_prev;
  logic [15:0] wheel_time_prev;
  logic        crank_armed;
  logic [15:0] crank_revs_prev;
  logic [15:0] crank_time_prev;

  // stimulus-side sensor cursors
  logic [31:0] sensor_wheel_revs = '0;
  logic [15:0] sensor_wheel_time = '0;
  logic [15:0] sensor_crank_revs = '0;
  logic [15:0] sensor_crank_time = '0;

  out_item_t expected_rates[$];
  out_item_t rate_want;
  int error_count    = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_req       = 0;
  int hold_seen      = 0;
  int hold_left      = 0;

  wheel_crank_rate_calculator_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(CLK_HALF) clk = ~clk;

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
    error_count++;
  endtask

  task automatic reset_predictor();
    cur_circumference = CIRCUMFERENCE_RESET;
    cur_speed_limit   = SPEED_LIMIT_RESET;
    cur_cadence_limit = CADENCE_LIMIT_RESET;
    wheel_armed       = 1'b0;
    wheel_revs_prev   = '0;
    wheel_time_prev   = '0;
    crank_armed       = 1'b0;
    crank_revs_prev   = '0;
    crank_time_prev   = '0;
  endtask

  function automatic out_item_t compute_rate(in_item_t rpt);
    out_item_t   res;
    logic [31:0] wheel_drev;
    logic [15:0] crank_drev;
    logic [15:0] dt;
    logic [63:0] num;
    logic [63:0] den;
    logic [31:0] rpm;
    res.rate_value = '0;
    if (rpt.func == FUNC_WHEEL) begin
      if (!wheel_armed) begin
        wheel_armed     = 1'b1;
        wheel_revs_prev = rpt.rev_count;
        wheel_time_prev = rpt.event_time;
        res.status      = STATUS_FIRST;
      end else begin
        wheel_drev      = rpt.rev_count - wheel_revs_prev;
        dt              = rpt.event_time - wheel_time_prev;
        wheel_revs_prev = rpt.rev_count;
        wheel_time_prev = rpt.event_time;
        if (wheel_drev == 0 || dt == 0) begin
          res.status = STATUS_STILL;
        end else begin
          num = {32'd0, wheel_drev};
          num = num * {48'd0, cur_circumference} * 64'd1024 * 64'd36;
          den = {48'd0, dt};
          den = den * 64'd100;
          num = num / den;
          if (num > {48'd0, cur_speed_limit}) begin
            res.status = STATUS_LIMIT;
          end else begin
            res.rate_value = num[15:0];
            res.status     = STATUS_OK;
          end
        end
      end
    end else begin
      if (!crank_armed) begin
        crank_armed     = 1'b1;
        crank_revs_prev = rpt.rev_count[15:0];
        crank_time_prev = rpt.event_time;
        res.status      = STATUS_FIRST;
      end else begin
        crank_drev      = rpt.rev_count[15:0] - crank_revs_prev;
        dt              = rpt.event_time - crank_time_prev;
        crank_revs_prev = rpt.rev_count[15:0];
        crank_time_prev = rpt.event_time;
        if (crank_drev == 0 || dt == 0) begin
          res.status = STATUS_STILL;
        end else begin
          rpm = {16'd0, crank_drev};
          rpm = rpm * 32'd60 * 32'd1024;
          rpm = rpm / {16'd0, dt};
          if (rpm > {24'd0, cur_cadence_limit}) begin
            res.status = STATUS_LIMIT;
          end else begin
            res.rate_value = rpm[15:0];
            res.status     = STATUS_OK;
          end
        end
      end
    end
    return res;
  endfunction

  function automatic in_item_t make_report(logic func, logic [31:0] revs, logic [15:0] t);
    in_item_t r;
    r.func       = func;
    r.rev_count  = revs;
    r.event_time = t;
    return r;
  endfunction

  task automatic send_report(in_item_t rpt);
    if (rpt.func == FUNC_WHEEL) begin
      sensor_wheel_revs = rpt.rev_count;
      sensor_wheel_time = rpt.event_time;
    end else begin
      sensor_crank_revs = rpt.rev_count[15:0];
      sensor_crank_time = rpt.event_time;
    end
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= rpt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_rates.push_back(compute_rate(rpt));
  endtask

  task automatic wheel_step(logic [31:0] drev, logic [15:0] dt);
    send_report(make_report(FUNC_WHEEL, sensor_wheel_revs + drev, sensor_wheel_time + dt));
  endtask

  task automatic crank_step(logic [15:0] drev, logic [15:0] dt);
    logic [31:0] revs;
    revs       = $urandom;
    revs[15:0] = sensor_crank_revs + drev;
    send_report(make_report(FUNC_CRANK, revs, sensor_crank_time + dt));
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_CIRCUMFERENCE: begin
        if (val != 0) cur_circumference = val;
      end
      REG_SPEED_LIMIT: begin
        cur_speed_limit = val;
      end
      REG_CADENCE_LIMIT: begin
        cur_cadence_limit = val[7:0];
      end
      default: begin
      end
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic quiesce();
    in_valid <= 1'b0;
    while (expected_rates.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_idling(int send_pct, int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct <= recv_pct;
  endtask

  task automatic randomise_settings();
    logic [15:0] v;
    quiesce();
    if ($urandom_range(3) == 0) v = $urandom_range(1) ? 16'd1 : 16'hFFFF;
    else v = 16'($urandom_range(500, 4000));
    write_reg(REG_CIRCUMFERENCE, v);
    if ($urandom_range(3) == 0) v = $urandom_range(1) ? 16'd0 : 16'hFFFF;
    else v = 16'($urandom_range(3000, 65535));
    write_reg(REG_SPEED_LIMIT, v);
    v = 16'($urandom);
    if ($urandom_range(3) == 0) v[7:0] = $urandom_range(1) ? 8'd0 : 8'hFF;
    else v[7:0] = 8'($urandom_range(150, 255));
    write_reg(REG_CADENCE_LIMIT, v);
  endtask

  task automatic send_random_reports(int count);
    int   pick;
    logic still;
    for (int i = 0; i < count; i++) begin
      pick  = $urandom_range(99);
      still = ($urandom_range(19) == 0);
      if (pick < 84) begin
        if ($urandom_range(1)) crank_step(still ? 16'd0 : 16'($urandom_range(1, 2)),
                                          16'($urandom_range(250, 2000)));
        else wheel_step(still ? 32'd0 : 32'($urandom_range(1, 3)),
                        16'($urandom_range(300, 3000)));
      end else begin
        send_report(make_report(1'($urandom_range(1)), $urandom, 16'($urandom)));
      end
    end
  endtask

  task automatic test_directed_reports();
    set_idling(0, 0);
    send_report(make_report(FUNC_WHEEL, 32'd0, 16'd0));
    wheel_step(0, 1000);
    wheel_step(1, 0);
    wheel_step(2, 1024);
    send_report(make_report(FUNC_WHEEL, 32'hFFFF_FFFF, 16'hFFFF));
    send_report(make_report(FUNC_WHEEL, 32'h0000_0001, 16'h03FF));
    wheel_step(32'hFFFF_FFFF, 1);
    send_report(make_report(FUNC_CRANK, 32'hFFFF_FFFF, 16'd0));
    crank_step(0, 500);
    crank_step(2, 1024);
    crank_step(1, 245);
    crank_step(1, 244);
    crank_step(16'hFFFF, 16'hFFFF);
    send_report(make_report(FUNC_CRANK, 32'h0000_0000, 16'hFFFF));
  endtask

  task automatic test_register_extremes();
    quiesce();
    write_reg(REG_CIRCUMFERENCE, 16'd1);
    write_reg(REG_SPEED_LIMIT, 16'hFFFF);
    write_reg(REG_CADENCE_LIMIT, 16'h00FF);
    wheel_step(1, 1);
    crank_step(4, 1024);
    crank_step(1, 241);
    quiesce();
    write_reg(REG_CIRCUMFERENCE, 16'hFFFF);
    write_reg(REG_SPEED_LIMIT, 16'd0);
    write_reg(REG_CADENCE_LIMIT, 16'hFF00);
    wheel_step(1, 1024);
    crank_step(1, 1024);
    crank_step(0, 10);
    quiesce();
    // zero circumference and unused index leave the registers alone
    write_reg(REG_CIRCUMFERENCE, 16'd0);
    write_reg(REG_SPEED_LIMIT, 16'hFFFF);
    write_reg(REG_UNUSED, 16'hFFFF);
    wheel_step(1, 16'hFFFF);
  endtask

  task automatic test_streaming();
    randomise_settings();
    set_idling(0, 0);
    send_random_reports(150);
  endtask

  task automatic test_sender_gaps();
    randomise_settings();
    set_idling(86, 0);
    send_random_reports(130);
  endtask

  task automatic test_receiver_stalls();
    randomise_settings();
    set_idling(0, 86);
    send_random_reports(130);
  endtask

  task automatic test_sparse_idling();
    randomise_settings();
    set_idling(7, 7);
    send_random_reports(150);
  endtask

  task automatic test_output_backpressure();
    randomise_settings();
    set_idling(0, 0);
    hold_req <= hold_req + 1;
    send_random_reports(70);
  endtask

  task automatic finish_run();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    set_idling(0, 0);
    while (expected_rates.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_rates.size() != 0)
      report_mismatch("items never returned", expected_rates.size(), 0);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  endtask

  // result checking and receiver readiness
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_rates.size() == 0) begin
        report_mismatch("unexpected item status", int'(out_data.status), 0);
      end else begin
        rate_want = expected_rates.pop_front();
        if (out_data.status != rate_want.status)
          report_mismatch("status", int'(out_data.status), int'(rate_want.status));
        if (out_data.rate_value != rate_want.rate_value)
          report_mismatch("rate_value", int'(out_data.rate_value),
                          int'(rate_want.rate_value));
      end
    end
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_LEN;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    reset_predictor();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_reports();
    test_register_extremes();
    test_streaming();
    test_sender_gaps();
    test_receiver_stalls();
    test_sparse_idling();
    test_output_backpressure();
    finish_run();
  end

endmodule
